/* hw/rtl/bll_pkg.sv */
// Shared constants and types for the binary-lifting lowest-common-ancestor block.
`timescale 1ns / 1ps

package bll_pkg;

    // Tree size and jump table geometry.
    localparam int MAX_NODES   = 1024;
    localparam int LIFT_LEVELS = 10;
    localparam int NODE_W      = 10;
    localparam int LEVEL_W     = 4;
    localparam int CNT_W       = 11;
    localparam int JT_ADDR_W   = LEVEL_W + NODE_W;
    localparam int JT_DEPTH    = LIFT_LEVELS * MAX_NODES;

    // Stream payload widths.
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 16;
    localparam int CMD_W      = 2;

    // Reset value of the node count register.
    localparam logic [CNT_W-1:0] NODE_COUNT_RESET = CNT_W'(MAX_NODES);

    // Command carried on the input tuser.
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_BUILD = 2'd1,
        CMD_QUERY = 2'd2
    } t_cmd;

endpackage

/* hw/rtl/binary_lifting_lca.sv */
// Top level of the binary-lifting lowest-common-ancestor engine.
`timescale 1ns / 1ps

// Lowest-common-ancestor engine over a rooted tree of up to 1024 nodes. A load beat
// (tuser 0) stores one node's parent and depth; node 0 is the root and must be loaded
// as its own parent. A build beat (tuser 1) fills jump levels 1 to 9 for nodes 0 ..
// node_count-1, with node_count capped at 1024, by two table reads and a write per
// node and level; a zero count builds nothing. A query beat (tuser 2) returns one
// result beat; it walks the jump table through a single sequencer with a two-port
// table read: it compares the depths, reads each lifting level and writes back when
// that depth-difference bit is set, checks for equality, and if the nodes still
// differ climbs with a read and a write-back per level and takes the final parent
// step; it then loads the output register once that register is free. The block
// takes no new beat while a command is in progress, but a finished result may wait in
// the output register while the next beat is accepted.
// node_count may only be written while the block is idle.
module binary_lifting_lca (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration: node count used by the table build.
    input  logic                           i_cfg_we,
    input  logic [bll_pkg::CNT_W-1:0]      i_cfg_data,
    // Input stream. tdata from bit 0: first_node[9:0], second_node[9:0], depth[9:0].
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [bll_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: cmd[1:0].
    input  logic [bll_pkg::CMD_W-1:0]      s_axis_tuser,
    // Output stream. tdata from bit 0: ancestor[9:0].
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [bll_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    import bll_pkg::*;

    typedef enum logic [12:0] {
        ST_IDLE     = 13'b0000000000001,
        ST_CMP      = 13'b0000000000010,
        ST_LIFT_RD  = 13'b0000000000100,
        ST_LIFT_WB  = 13'b0000000001000,
        ST_EQ       = 13'b0000000010000,
        ST_CLIMB_RD = 13'b0000000100000,
        ST_CLIMB_WB = 13'b0000001000000,
        ST_FIN_RD   = 13'b0000010000000,
        ST_FIN_WB   = 13'b0000100000000,
        ST_RESULT   = 13'b0001000000000,
        ST_BLD_RD1  = 13'b0010000000000,
        ST_BLD_RD2  = 13'b0100000000000,
        ST_BLD_WR   = 13'b1000000000000
    } t_state;

    localparam logic [LEVEL_W-1:0] LAST_LEVEL = LEVEL_W'(LIFT_LEVELS - 1);

    // Input field split.
    logic [NODE_W-1:0] in_first;
    logic [NODE_W-1:0] in_second;
    logic [NODE_W-1:0] in_depth;
    t_cmd              in_cmd;

    assign in_first  = s_axis_tdata[NODE_W-1:0];
    assign in_second = s_axis_tdata[2*NODE_W-1:NODE_W];
    assign in_depth  = s_axis_tdata[3*NODE_W-1:2*NODE_W];
    assign in_cmd    = t_cmd'(s_axis_tuser);

    // Control and datapath registers.
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_node_count;
    logic              r_out_valid, n_out_valid;
    logic [NODE_W-1:0] r_out_data, n_out_data;
    logic [NODE_W-1:0] r_u, n_u;
    logic [NODE_W-1:0] r_v, n_v;
    logic [NODE_W-1:0] r_diff, n_diff;
    logic [NODE_W-1:0] r_ans, n_ans;
    logic [LEVEL_W-1:0] r_k, n_k;
    logic [NODE_W-1:0] r_j, n_j;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    // Memories and their registered read data.
    logic [NODE_W-1:0] r_jump_mem [0:JT_DEPTH-1];
    logic [NODE_W-1:0] r_depth_mem [0:MAX_NODES-1];
    logic [NODE_W-1:0] r_jt_rd0, r_jt_rd1;
    logic [NODE_W-1:0] r_dep_rd0, r_dep_rd1;

    logic                 jt_we;
    logic [JT_ADDR_W-1:0] jt_wa;
    logic [NODE_W-1:0]    jt_wd;
    logic [JT_ADDR_W-1:0] jt_ra0, jt_ra1;
    logic                 dep_we;

    logic [LEVEL_W-1:0]   k_prev;
    logic [CNT_W-1:0]     j_next;
    logic                 out_free;

    assign k_prev   = r_k - LEVEL_W'(1);
    assign j_next   = {1'b0, r_j} + CNT_W'(1);
    assign out_free = !r_out_valid || m_axis_tready;

    // Sequencer and shared datapath.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_u         = r_u;
        n_v         = r_v;
        n_diff      = r_diff;
        n_ans       = r_ans;
        n_k         = r_k;
        n_j         = r_j;
        n_cnt       = r_cnt;
        jt_we       = 1'b0;
        jt_wa       = '0;
        jt_wd       = in_second;
        jt_ra0      = '0;
        jt_ra1      = '0;
        dep_we      = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    case (in_cmd)
                        CMD_LOAD: begin
                            dep_we = 1'b1;
                            jt_we  = 1'b1;
                            jt_wa  = {LEVEL_W'(0), in_first};
                            jt_wd  = in_second;
                        end
                        CMD_BUILD: begin
                            n_cnt = (r_node_count > CNT_W'(MAX_NODES)) ?
                                    CNT_W'(MAX_NODES) : r_node_count;
                            n_k   = LEVEL_W'(1);
                            n_j   = '0;
                            if (r_node_count != '0 && LIFT_LEVELS > 1) begin
                                n_state = ST_BLD_RD1;
                            end
                        end
                        CMD_QUERY: begin
                            n_u     = in_first;
                            n_v     = in_second;
                            n_state = ST_CMP;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // Depths arrived from the read issued on the accepted beat; keep v deeper.
            ST_CMP: begin
                if (r_dep_rd1 < r_dep_rd0) begin
                    n_u    = r_v;
                    n_v    = r_u;
                    n_diff = r_dep_rd0 - r_dep_rd1;
                end else begin
                    n_diff = r_dep_rd1 - r_dep_rd0;
                end
                n_k     = '0;
                n_state = ST_LIFT_RD;
            end
            // Lift v by one bit of the depth difference per level.
            ST_LIFT_RD: begin
                jt_ra0 = {r_k, r_v};
                if (r_diff[r_k]) begin
                    n_state = ST_LIFT_WB;
                end else if (r_k == LAST_LEVEL) begin
                    n_state = ST_EQ;
                end else begin
                    n_k = r_k + LEVEL_W'(1);
                end
            end
            ST_LIFT_WB: begin
                n_v = r_jt_rd0;
                if (r_k == LAST_LEVEL) begin
                    n_state = ST_EQ;
                end else begin
                    n_k     = r_k + LEVEL_W'(1);
                    n_state = ST_LIFT_RD;
                end
            end
            ST_EQ: begin
                if (r_u == r_v) begin
                    n_ans   = r_u;
                    n_state = ST_RESULT;
                end else begin
                    n_k     = LAST_LEVEL;
                    n_state = ST_CLIMB_RD;
                end
            end
            // Climb both nodes by falling powers of two while their ancestors differ.
            ST_CLIMB_RD: begin
                jt_ra0  = {r_k, r_u};
                jt_ra1  = {r_k, r_v};
                n_state = ST_CLIMB_WB;
            end
            ST_CLIMB_WB: begin
                if (r_jt_rd0 != r_jt_rd1) begin
                    n_u = r_jt_rd0;
                    n_v = r_jt_rd1;
                end
                if (r_k == '0) begin
                    n_state = ST_FIN_RD;
                end else begin
                    n_k     = k_prev;
                    n_state = ST_CLIMB_RD;
                end
            end
            // The answer is the parent of the final u.
            ST_FIN_RD: begin
                jt_ra0  = {LEVEL_W'(0), r_u};
                n_state = ST_FIN_WB;
            end
            ST_FIN_WB: begin
                n_ans   = r_jt_rd0;
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_ans;
                    n_state     = ST_IDLE;
                end
            end
            // Build: level k of node j is level k-1 applied twice.
            ST_BLD_RD1: begin
                jt_ra0  = {k_prev, r_j};
                n_state = ST_BLD_RD2;
            end
            ST_BLD_RD2: begin
                jt_ra0  = {k_prev, r_jt_rd0};
                n_state = ST_BLD_WR;
            end
            ST_BLD_WR: begin
                jt_we = 1'b1;
                jt_wa = {r_k, r_j};
                jt_wd = r_jt_rd0;
                if (j_next == r_cnt) begin
                    n_j = '0;
                    if (r_k == LAST_LEVEL) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_k     = r_k + LEVEL_W'(1);
                        n_state = ST_BLD_RD1;
                    end
                end else begin
                    n_j     = j_next[NODE_W-1:0];
                    n_state = ST_BLD_RD1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_node_count <= NODE_COUNT_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_node_count <= i_cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_u        <= n_u;
        r_v        <= n_v;
        r_diff     <= n_diff;
        r_ans      <= n_ans;
        r_k        <= n_k;
        r_j        <= n_j;
        r_cnt      <= n_cnt;
    end

    // Jump table: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (jt_we) begin
            r_jump_mem[jt_wa] <= jt_wd;
        end
        r_jt_rd0 <= r_jump_mem[jt_ra0];
        r_jt_rd1 <= r_jump_mem[jt_ra1];
    end

    // Depth store: read at both input nodes on every cycle so a query has them next.
    always_ff @(posedge i_clk) begin
        if (dep_we) begin
            r_depth_mem[in_first] <= in_depth;
        end
        r_dep_rd0 <= r_depth_mem[in_first];
        r_dep_rd1 <= r_depth_mem[in_second];
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W - NODE_W){1'b0}}, r_out_data};

endmodule

/* test/binary_lifting_lca_tb.sv */
// Self-checking testbench for the binary-lifting lowest-common-ancestor engine.
`timescale 1ns / 1ps

module binary_lifting_lca_tb;
    import bll_pkg::*;

    // The command code that the block ignores.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT        = 200000;
    localparam int HOLD_OFF_CYCLES       = 300;
    localparam int BUILD_CYCLES_PER_NODE = 27;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CNT_W-1:0]      i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // tdata from bit 0: first_node[9:0], second_node[9:0], depth[9:0].
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    // tuser: cmd[1:0].
    logic [CMD_W-1:0]      s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // tdata from bit 0: ancestor[9:0].
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // Shadow copy of the tree: jump levels, depths and the node count register.
    logic [NODE_W-1:0] jump_q [LIFT_LEVELS][MAX_NODES];
    logic [NODE_W-1:0] depth_q [MAX_NODES];
    logic [CNT_W-1:0]  node_count_q = NODE_COUNT_RESET;

    // Ancestors still owed by the block, oldest first.
    logic [NODE_W-1:0] pending_ancestors [$];

    int   fail_count  = 0;
    int   quiet_tail  = 0;
    int   quiet_cycles = 0;
    logic calm        = 1'b0;
    logic holding     = 1'b0;
    event hold_off_go;

    binary_lifting_lca dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Fill jump levels 1 and up for the nodes the count covers; returns how many.
    function automatic int build_jumps();
        int span;
        span = (node_count_q > CNT_W'(MAX_NODES)) ? MAX_NODES : int'(node_count_q);
        for (int k = 1; k < LIFT_LEVELS; k++) begin
            for (int j = 0; j < span; j++) begin
                jump_q[k][j] = jump_q[k-1][jump_q[k-1][j]];
            end
        end
        return span;
    endfunction

    // Lift the deeper node to the same depth, then climb both while they differ.
    function automatic logic [NODE_W-1:0] common_ancestor(input logic [NODE_W-1:0] a,
                                                          input logic [NODE_W-1:0] b);
        logic [NODE_W-1:0] u, v, du, dv, t, diff, pu, pv;
        u  = a;
        v  = b;
        du = depth_q[a];
        dv = depth_q[b];
        if (dv < du) begin
            t = u; u = v; v = t;
            t = du; du = dv; dv = t;
        end
        diff = dv - du;
        for (int k = 0; k < LIFT_LEVELS; k++) begin
            if (diff[k]) v = jump_q[k][v];
        end
        if (u == v) return u;
        for (int k = LIFT_LEVELS - 1; k >= 0; k--) begin
            pu = jump_q[k][u];
            pv = jump_q[k][v];
            if (pu != pv) begin
                u = pu;
                v = pv;
            end
        end
        return jump_q[0][u];
    endfunction

    // Apply one accepted beat to the shadow state and note how long it keeps the block busy.
    function automatic void predict_beat(input logic [CMD_W-1:0] cmd,
                                         input logic [NODE_W-1:0] a,
                                         input logic [NODE_W-1:0] b,
                                         input logic [NODE_W-1:0] d);
        case (cmd)
            CMD_LOAD: begin
                depth_q[a]   = d;
                jump_q[0][a] = b;
                quiet_tail   = 4;
            end
            CMD_BUILD: begin
                quiet_tail = BUILD_CYCLES_PER_NODE * build_jumps() + 8;
            end
            CMD_QUERY: begin
                pending_ancestors.push_back(common_ancestor(a, b));
                quiet_tail = 0;
            end
            default: begin
                quiet_tail = 4;
            end
        endcase
    endfunction

    function automatic logic [NODE_W-1:0] rnd_node();
        return NODE_W'($urandom);
    endfunction

    // Offer one beat, with an occasional gap before it, and wait until it is taken.
    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [NODE_W-1:0] a,
                             input logic [NODE_W-1:0] b, input logic [NODE_W-1:0] d);
        int gap;
        gap = (!calm && $urandom_range(0, 99) < 8) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= IN_DATA_W'({d, b, a});
        do @(posedge i_clk); while (!s_axis_tready);
        predict_beat(cmd, a, b, d);
    endtask

    // Wait until every result is in and the last command has surely finished.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_ancestors.size() != 0) @(posedge i_clk);
        repeat (quiet_tail + 32) @(posedge i_clk);
    endtask

    task automatic set_node_count(input logic [CNT_W-1:0] value);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        node_count_q = value;
    endtask

    // Load nodes 0 .. n-1 as a well-formed tree; each parent is at most reach+1 below.
    task automatic load_tree(input int n, input int reach);
        logic [NODE_W-1:0] up, dep;
        for (int i = 0; i < n; i++) begin
            if (i == 0) begin
                up  = '0;
                dep = '0;
            end else begin
                up  = NODE_W'(i - 1 - $urandom_range(0, (reach < i - 1) ? reach : i - 1));
                dep = depth_q[up] + NODE_W'(1);
            end
            send_beat(CMD_LOAD, NODE_W'(i), up, dep);
        end
    endtask

    // Query a random pair below n; some pairs are equal or an ancestor chain apart.
    task automatic send_query(input int n);
        logic [NODE_W-1:0] a, b;
        int steps;
        a = NODE_W'($urandom_range(0, n - 1));
        b = NODE_W'($urandom_range(0, n - 1));
        case ($urandom_range(0, 7))
            0: b = a;
            1, 2: begin
                b     = a;
                steps = $urandom_range(0, 24);
                repeat (steps) b = jump_q[0][b];
            end
            default: ;
        endcase
        if ($urandom_range(0, 1) != 0) begin
            send_beat(CMD_QUERY, b, a, rnd_node());
        end else begin
            send_beat(CMD_QUERY, a, b, rnd_node());
        end
    endtask

    // Queries with an ignored command mixed in now and then.
    task automatic query_run(input int n, input int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 15) == 0) send_beat(CMD_UNUSED, rnd_node(), rnd_node(), rnd_node());
            send_query(n);
        end
    endtask

    // Eight-node tree with hand-picked pairs.
    task automatic test_directed_small_tree();
        set_node_count(CNT_W'(8));
        send_beat(CMD_LOAD, 10'd0, 10'd0, 10'd0);
        send_beat(CMD_LOAD, 10'd1, 10'd0, 10'd1);
        send_beat(CMD_LOAD, 10'd2, 10'd0, 10'd1);
        send_beat(CMD_LOAD, 10'd3, 10'd1, 10'd2);
        send_beat(CMD_LOAD, 10'd4, 10'd1, 10'd2);
        send_beat(CMD_LOAD, 10'd5, 10'd3, 10'd3);
        send_beat(CMD_LOAD, 10'd6, 10'd5, 10'd4);
        send_beat(CMD_LOAD, 10'd7, 10'd2, 10'd2);
        // The unused command with every bit set must leave the tree alone.
        send_beat(CMD_UNUSED, '1, '1, '1);
        send_beat(CMD_BUILD, '0, '0, '0);
        // Root with itself, root against the deepest node both ways round.
        send_beat(CMD_QUERY, 10'd0, 10'd0, '0);
        send_beat(CMD_QUERY, 10'd6, 10'd0, '0);
        send_beat(CMD_QUERY, 10'd0, 10'd6, '0);
        // Cousins, nodes in different subtrees, and a node against its own ancestor.
        send_beat(CMD_QUERY, 10'd6, 10'd4, '0);
        send_beat(CMD_QUERY, 10'd6, 10'd7, '0);
        send_beat(CMD_QUERY, 10'd5, 10'd6, '0);
        send_beat(CMD_QUERY, 10'd3, 10'd4, '0);
        send_beat(CMD_QUERY, 10'd7, 10'd7, '0);
        send_beat(CMD_QUERY, 10'd4, 10'd2, '0);
        // The depth field of a query is ignored.
        send_beat(CMD_QUERY, 10'd6, 10'd3, '1);
        // A build with a zero count changes nothing.
        set_node_count('0);
        send_beat(CMD_BUILD, '1, '1, '1);
        send_beat(CMD_QUERY, 10'd6, 10'd4, '0);
    endtask

    task automatic test_small_random_tree();
        int n;
        n = $urandom_range(2, 40);
        set_node_count(CNT_W'(n));
        load_tree(n, $urandom_range(0, 4));
        send_beat(CMD_BUILD, rnd_node(), rnd_node(), rnd_node());
        query_run(n, 40);
    endtask

    // All 1024 nodes in a deep, narrow tree, built with a count above the table size.
    task automatic test_full_tree_oversized_count();
        set_node_count('1);
        load_tree(MAX_NODES, 1);
        send_beat(CMD_BUILD, rnd_node(), rnd_node(), rnd_node());
        calm <= 1'b1;
        query_run(MAX_NODES, 30);
        // The receiver holds off while queries keep coming, so the block backs up.
        -> hold_off_go;
        query_run(MAX_NODES, 20);
        calm <= 1'b0;
        query_run(MAX_NODES, 20);
    endtask

    // Random parents and depths that need not form a tree.
    task automatic test_inconsistent_rebuild();
        set_node_count(CNT_W'(MAX_NODES));
        for (int i = 0; i < 25; i++) begin
            if ($urandom_range(0, 7) == 0) send_beat(CMD_UNUSED, rnd_node(), rnd_node(), rnd_node());
            send_beat(CMD_LOAD, rnd_node(), rnd_node(), rnd_node());
        end
        send_beat(CMD_BUILD, rnd_node(), rnd_node(), rnd_node());
        query_run(MAX_NODES, 50);
    endtask

    task automatic test_single_node_count();
        set_node_count(CNT_W'(1));
        send_beat(CMD_BUILD, rnd_node(), rnd_node(), rnd_node());
        query_run(MAX_NODES, 15);
    endtask

    task automatic test_zero_node_count();
        set_node_count('0);
        for (int i = 0; i < 8; i++) begin
            send_beat(CMD_LOAD, rnd_node(), rnd_node(), rnd_node());
        end
        send_beat(CMD_BUILD, rnd_node(), rnd_node(), rnd_node());
        query_run(MAX_NODES, 15);
    endtask

    // Result side: random back-pressure and comparison with the oldest expectation.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_ancestors.size() == 0) begin
                    $error("unexpected result beat: ancestor %0d", m_axis_tdata[NODE_W-1:0]);
                    fail_count++;
                end else begin
                    if (m_axis_tdata[NODE_W-1:0] !== pending_ancestors[0]) begin
                        $error("ancestor mismatch: expected %0d, actual %0d",
                               pending_ancestors[0], m_axis_tdata[NODE_W-1:0]);
                        fail_count++;
                    end
                    void'(pending_ancestors.pop_front());
                end
            end
            m_axis_tready <= !holding && (calm || $urandom_range(0, 99) >= 8);
        end
    end

    // Long receiver hold-off, counted here.
    always begin
        @(hold_off_go);
        holding <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
        holding <= 1'b0;
    end

    // Watchdog on cycles in which neither side moves a beat.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_small_tree();
        test_small_random_tree();
        test_full_tree_oversized_count();
        test_inconsistent_rebuild();
        test_single_node_count();
        test_zero_node_count();
        settle();

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/bll_pkg.sv
hw/rtl/binary_lifting_lca.sv
test/binary_lifting_lca_tb.sv
